// ===== hw/rtl/apcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass cascade decorrelator package
// Shared constants, register indexes, sequencer step codes and the microcode
// table that drives the allpass datapath.
// ----------------------------------------------------------------------------
package apcd_pkg;

    localparam int MAX_STAGES   = 4;
    localparam int MAX_DELAY    = 1024;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEFF_WIDTH  = 16;

    localparam int CFG_IDX_W      = 3;
    localparam int NUM_W          = 3;
    localparam int NUM_DELAY_REGS = 4;

    localparam int REG_NUM_STAGES = 0;
    localparam int REG_GAIN       = 1;
    localparam int REG_DELAY0     = 2;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_Y,
        ST_MUL,
        ST_WR,
        ST_DONE
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN,
        C_MORE,
        C_OUT,
        C_CLR
    } t_cond;

    typedef struct packed {
        logic  ready;
        logic  mem_rd;
        logic  mul_en;
        logic  mul_sel;
        logic  ld_y;
        logic  mem_wr;
        logic  emit;
        logic  clr;
        t_cond cond;
        t_step tgt;
        t_step alt;
    } t_uword;

    // One control word per step. The condition picks between the target and
    // the alternative step, or holds the current step while it is false.
    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        w      = '0;
        w.cond = C_ALWAYS;
        w.tgt  = ST_IDLE;
        w.alt  = ST_IDLE;
        case (s)
            ST_CLR: begin
                w.clr  = 1'b1;
                w.cond = C_CLR;
                w.tgt  = ST_IDLE;
            end
            ST_IDLE: begin
                w.ready = 1'b1;
                w.cond  = C_IN;
                w.tgt   = ST_RD;
                w.alt   = ST_DONE;
            end
            ST_RD: begin
                w.mem_rd = 1'b1;
                w.mul_en = 1'b1;
                w.tgt    = ST_Y;
            end
            ST_Y: begin
                w.ld_y = 1'b1;
                w.tgt  = ST_MUL;
            end
            ST_MUL: begin
                w.mul_en  = 1'b1;
                w.mul_sel = 1'b1;
                w.tgt     = ST_WR;
            end
            ST_WR: begin
                w.mem_wr = 1'b1;
                w.cond   = C_MORE;
                w.tgt    = ST_RD;
                w.alt    = ST_DONE;
            end
            ST_DONE: begin
                w.emit = 1'b1;
                w.cond = C_OUT;
                w.tgt  = ST_IDLE;
            end
            default: begin
                w.tgt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/allpass_cascade_decorrelator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass cascade decorrelator
// A chain of up to MAX_STAGES Schroeder allpass stages sharing one multiplier
// and one delay memory, sequenced by a small microcode table.
// ----------------------------------------------------------------------------
// A sample beat passes through one step to take the beat, four steps per stage
// in use (delay read with the first product, the stage output, the second
// product, the delay write-back) through the shared multiplier and the
// single-port delay memory, and one step to load the output register. The
// output register lets the next beat be taken while a result still waits.
// After reset the delay memory, all MAX_STAGES*MAX_DELAY entries (4096 by
// default), is cleared one entry a cycle, and no sample beat is taken until
// it is done; configuration writes are taken at any time but must only be
// made while the block is idle.
module allpass_cascade_decorrelator #(
    parameter int MAX_STAGES   = apcd_pkg::MAX_STAGES,
    parameter int MAX_DELAY    = apcd_pkg::MAX_DELAY,
    parameter int SAMPLE_WIDTH = apcd_pkg::SAMPLE_WIDTH,
    parameter int COEFF_WIDTH  = apcd_pkg::COEFF_WIDTH,
    localparam int LW    = $clog2(MAX_DELAY + 1),
    localparam int CFG_W = (COEFF_WIDTH > LW) ? COEFF_WIDTH : LW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]                    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEFF_WIDTH;
    localparam int DEPTH = MAX_STAGES * MAX_DELAY;
    localparam int AW    = $clog2(DEPTH);
    localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int PW    = $clog2(MAX_DELAY);
    localparam int NCW   = ($clog2(MAX_STAGES + 1) > apcd_pkg::NUM_W) ?
                           $clog2(MAX_STAGES + 1) : apcd_pkg::NUM_W;
    localparam int DIW   = (CFG_W < 15) ? CFG_W : 15;
    localparam int PRW   = SW + CW;
    localparam int XW    = SW + 2;

    // Saturate a widened value to the sample range.
    function automatic logic signed [SW-1:0] sat_s(input logic signed [XW-1:0] v);
        logic [XW-SW:0] top;
        top = v[XW-1:SW-1];
        if (top == '0 || top == '1) begin
            return v[SW-1:0];
        end else if (v[XW-1]) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    // Round a Q1.15 by Q1.23 product to nearest, ties upward, and saturate.
    function automatic logic signed [SW-1:0] scale(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] t;
        t = (p + $signed({{(PRW-CW+1){1'b0}}, 1'b1, {(CW-2){1'b0}}})) >>> (CW - 1);
        return sat_s(t[XW-1:0]);
    endfunction

    // Configuration
    logic [apcd_pkg::NUM_W-1:0] r_num;
    logic signed [CW-1:0]       r_gain;
    logic [LW-1:0]              r_len [MAX_STAGES];
    logic [PW-1:0]              r_ptr [MAX_STAGES];

    // Sequencer
    apcd_pkg::t_step  r_step;
    apcd_pkg::t_step  n_step;
    apcd_pkg::t_uword w_uw;
    logic [STG_W-1:0] r_stage;
    logic [AW-1:0]    r_clr_addr;
    logic             r_out_valid;

    // Datapath
    logic signed [SW-1:0]  r_x;
    logic signed [SW-1:0]  r_y;
    logic signed [SW-1:0]  r_rdata;
    logic signed [PRW-1:0] r_prod;
    logic signed [SW-1:0]  r_out;
    logic signed [SW-1:0]  mem [DEPTH];

    logic [NCW-1:0]        w_n_eff;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_emit;
    logic                  w_more;
    logic                  w_clr_last;
    logic                  w_mem_we;
    logic [AW-1:0]         w_addr;
    logic [AW-1:0]         w_mem_addr;
    logic signed [SW-1:0]  w_mem_wdata;
    logic [PW-1:0]         w_ptr;
    logic [PW-1:0]         w_ptr_next;
    logic signed [SW-1:0]  w_gs;
    logic signed [SW-1:0]  w_y;
    logic signed [SW-1:0]  w_wdata;
    logic signed [SW-1:0]  w_mop;
    logic [DIW-1:0]        w_dly_raw;
    logic [LW-1:0]         w_dly_len;

    assign w_n_eff = (NCW'(r_num) > NCW'(MAX_STAGES)) ? NCW'(MAX_STAGES) : NCW'(r_num);

    assign w_dly_raw = i_cfg_data[DIW-1:0];
    assign w_dly_len = (w_dly_raw == '0) ? LW'(1) :
                       (w_dly_raw > DIW'(MAX_DELAY)) ? LW'(MAX_DELAY) : LW'(w_dly_raw);

    assign w_ptr      = r_ptr[r_stage];
    assign w_ptr_next = ((LW'(w_ptr) + LW'(1)) >= r_len[r_stage]) ? '0 : w_ptr + PW'(1);
    assign w_addr     = AW'(r_stage) * AW'(MAX_DELAY) + AW'(w_ptr);

    assign w_gs    = scale(r_prod);
    assign w_y     = sat_s(XW'(r_rdata) - XW'(w_gs));
    assign w_wdata = sat_s(XW'(r_x) + XW'(w_gs));
    assign w_mop   = w_uw.mul_sel ? r_y : r_x;

    assign w_mem_we    = w_uw.mem_wr || w_uw.clr;
    assign w_mem_addr  = w_uw.clr ? r_clr_addr : w_addr;
    assign w_mem_wdata = w_uw.clr ? '0 : w_wdata;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // Next step and step outputs from the microcode table.
    always_comb begin
        w_uw       = apcd_pkg::uc_rom(r_step);
        o_in_ready = w_uw.ready;
        w_in_acc   = w_uw.ready && i_in_valid;
        w_out_free = !r_out_valid || i_out_ready;
        w_emit     = w_uw.emit && w_out_free;
        w_more     = (NCW'(r_stage) + NCW'(1)) < w_n_eff;
        w_clr_last = (r_clr_addr == AW'(DEPTH - 1));
        case (w_uw.cond)
            apcd_pkg::C_ALWAYS: n_step = w_uw.tgt;
            apcd_pkg::C_IN: begin
                if (w_in_acc) begin
                    n_step = (w_n_eff != '0) ? w_uw.tgt : w_uw.alt;
                end else begin
                    n_step = r_step;
                end
            end
            apcd_pkg::C_MORE: n_step = w_more ? w_uw.tgt : w_uw.alt;
            apcd_pkg::C_OUT:  n_step = w_out_free ? w_uw.tgt : r_step;
            apcd_pkg::C_CLR:  n_step = w_clr_last ? w_uw.tgt : r_step;
            default:          n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= apcd_pkg::ST_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num       <= '0;
            r_gain      <= $signed({2'b01, {(CW-2){1'b0}}});
            r_stage     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_len[i] <= LW'(1);
                r_ptr[i] <= '0;
            end
        end else begin
            if (w_uw.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_in_acc) begin
                r_stage <= '0;
            end else if (w_uw.mem_wr) begin
                r_stage <= r_stage + STG_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int i = 0; i < MAX_STAGES; i++) begin
                if (w_uw.mem_wr && (int'(r_stage) == i)) begin
                    r_ptr[i] <= w_ptr_next;
                end
            end
            if (i_cfg_we) begin
                if (int'(i_cfg_idx) == apcd_pkg::REG_NUM_STAGES) begin
                    r_num <= i_cfg_data[apcd_pkg::NUM_W-1:0];
                end
                if (int'(i_cfg_idx) == apcd_pkg::REG_GAIN) begin
                    r_gain <= $signed(i_cfg_data[CW-1:0]);
                end
                // A new delay length restarts that stage's pointer; the line
                // contents are kept.
                for (int i = 0; i < MAX_STAGES; i++) begin
                    if (i < apcd_pkg::NUM_DELAY_REGS &&
                        int'(i_cfg_idx) == apcd_pkg::REG_DELAY0 + i) begin
                        r_len[i] <= w_dly_len;
                        r_ptr[i] <= '0;
                    end
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= i_sample_in;
        end else if (w_uw.mem_wr) begin
            r_x <= r_y;
        end
        if (w_uw.mul_en) begin
            r_prod <= PRW'(r_gain) * PRW'(w_mop);
        end
        if (w_uw.ld_y) begin
            r_y <= w_y;
        end
        if (w_emit) begin
            r_out <= r_x;
        end
    end

    // Delay memory: one port, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_uw.mem_rd) begin
            r_rdata <= mem[w_mem_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == apcd_pkg::ST_CLR) |-> !o_in_ready)
        else $error("sample beat offered while the delay memory is cleared");

    a_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_uw.mem_rd))
        else $error("delay memory read and written in the same cycle");

    a_write_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_step == apcd_pkg::ST_WR || r_step == apcd_pkg::ST_CLR))
        else $error("delay memory written outside a write or clear step");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_step != apcd_pkg::ST_IDLE))
        else $error("sequencer stayed idle after taking a sample beat");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_step) == apcd_pkg::ST_DONE))
        else $error("result raised outside the output step");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allpass cascade decorrelator testbench
// Drives audio samples through the valid/ready input with random gaps and
// drains the output with random back-pressure. A behavioural copy of the
// allpass chain, including its delay lines and pointers, predicts every output
// sample, and each output beat is checked against the oldest prediction.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_STAGES     = apcd_pkg::MAX_STAGES;
    localparam int MAX_DELAY      = apcd_pkg::MAX_DELAY;
    localparam int SAMPLE_WIDTH   = apcd_pkg::SAMPLE_WIDTH;
    localparam int COEFF_WIDTH    = apcd_pkg::COEFF_WIDTH;
    localparam int CFG_IDX_W      = apcd_pkg::CFG_IDX_W;
    localparam int NUM_W          = apcd_pkg::NUM_W;
    localparam int NUM_DELAY_REGS = apcd_pkg::NUM_DELAY_REGS;
    localparam int REG_NUM_STAGES = apcd_pkg::REG_NUM_STAGES;
    localparam int REG_GAIN       = apcd_pkg::REG_GAIN;
    localparam int REG_DELAY0     = apcd_pkg::REG_DELAY0;

    localparam int DLY_W      = $clog2(MAX_DELAY + 1);
    localparam int CFG_DATA_W = (COEFF_WIDTH > DLY_W) ? COEFF_WIDTH : DLY_W;
    localparam int REG_SPARE  = REG_DELAY0 + NUM_DELAY_REGS;
    localparam int REG_LAST   = (1 << CFG_IDX_W) - 1;
    localparam int SETTLE_CYC = 4 * MAX_STAGES + 8;

    localparam longint S_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint S_MIN = -S_MAX - 1;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HI = SAMPLE_WIDTH'(S_MAX);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LO = SAMPLE_WIDTH'(S_MIN);

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_DATA_W-1:0]          i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_sample_in;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic signed [SAMPLE_WIDTH-1:0] o_sample_out;

    allpass_cascade_decorrelator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the block: delay lines, tap pointers and register contents.
    longint                   dline_mem [MAX_STAGES * MAX_DELAY];
    int unsigned              tap_ptr   [MAX_STAGES];
    int unsigned              cfg_delay [MAX_STAGES];
    logic [NUM_W-1:0]         cfg_stages;
    logic signed [COEFF_WIDTH-1:0] cfg_gain;

    logic signed [SAMPLE_WIDTH-1:0] chain_out_q [$];
    int  err_cnt;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  sink_hold_cycles;

    function automatic longint clip(input longint v);
        if (v > S_MAX) return S_MAX;
        if (v < S_MIN) return S_MIN;
        return v;
    endfunction

    // Q1.15 gain times a sample, rounded half up, then saturated.
    function automatic longint gain_mul(input longint v);
        longint p;
        p = longint'(cfg_gain) * v + (longint'(1) << (COEFF_WIDTH - 2));
        return clip(p >>> (COEFF_WIDTH - 1));
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] allpass_chain_step(
        input logic signed [SAMPLE_WIDTH-1:0] x_in
    );
        longint      x, d, y;
        int unsigned n, s, len, p, addr;
        x = x_in;
        n = (cfg_stages > MAX_STAGES) ? MAX_STAGES : cfg_stages;
        for (s = 0; s < n; s++) begin
            len = (cfg_delay[s] == 0) ? 1 :
                  (cfg_delay[s] > MAX_DELAY) ? MAX_DELAY : cfg_delay[s];
            p    = tap_ptr[s] % MAX_DELAY;
            addr = s * MAX_DELAY + p;
            d    = dline_mem[addr];
            y    = clip(d - gain_mul(x));
            dline_mem[addr] = clip(x + gain_mul(y));
            tap_ptr[s] = (p + 1 >= len) ? 0 : p + 1;
            x = y;
        end
        return SAMPLE_WIDTH'(x);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        logic signed [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(0, 5))
            0: v = SAMPLE_HI - SAMPLE_WIDTH'($urandom_range(0, 15));
            1: v = SAMPLE_LO + SAMPLE_WIDTH'($urandom_range(0, 15));
            2: begin
                v = SAMPLE_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
            end
            default: v = SAMPLE_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    // All tasks start and return just after a rising edge.
    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned s;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_NUM_STAGES) begin
            cfg_stages = val[NUM_W-1:0];
        end else if (idx == REG_GAIN) begin
            cfg_gain = val[COEFF_WIDTH-1:0];
        end else if (idx >= REG_DELAY0 && idx < REG_SPARE) begin
            s = idx - REG_DELAY0;
            cfg_delay[s] = 32'(val & 16'h7FFF);
            tap_ptr[s]   = 0;
        end
    endtask

    task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        chain_out_q.push_back(allpass_chain_step(x));
    endtask

    // Waits until every predicted sample has come out, then lets the
    // sequencer settle so that the block is idle for register writes.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (chain_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic test_passthrough();
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_LO);
        push_sample('0);
        push_sample(-1);
        push_sample(24'h555555);
        push_sample(24'hAAAAAA);
        drain();
    endtask

    task automatic test_saturation_and_limits();
        int idx;
        // More stages than exist, unity negative gain, and delay lengths of
        // zero and beyond the line size.
        write_reg(REG_NUM_STAGES, 7);
        write_reg(REG_GAIN, 16'h8000);
        write_reg(REG_DELAY0 + 0, 0);
        write_reg(REG_DELAY0 + 1, 2047);
        write_reg(REG_DELAY0 + 2, 1);
        write_reg(REG_DELAY0 + 3, 3);
        for (idx = REG_SPARE; idx <= REG_LAST; idx++)
            write_reg(idx, CFG_DATA_W'($urandom));
        push_sample(SAMPLE_LO);
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_LO);
        push_sample(SAMPLE_LO);
        push_sample(SAMPLE_HI);
        drain();
        write_reg(REG_GAIN, 16'h7FFF);
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_LO);
        push_sample(1);
        drain();
    endtask

    task automatic test_delay_rewrite();
        int k;
        write_reg(REG_NUM_STAGES, 2);
        write_reg(REG_GAIN, 16'd16384);
        write_reg(REG_DELAY0 + 0, 7);
        for (k = 0; k < 4; k++) push_sample(rand_sample());
        drain();
        // Shorter length: the pointer restarts but the old line contents stay.
        write_reg(REG_DELAY0 + 0, 2);
        push_sample(SAMPLE_HI);
        push_sample(SAMPLE_LO);
        drain();
        // Stages two and three come back into use with their untouched lines.
        write_reg(REG_NUM_STAGES, 4);
        push_sample(12345);
        push_sample(-54321);
        drain();
    endtask

    task automatic pick_setting(input int phase);
        int s;
        logic [CFG_DATA_W-1:0] g;
        case (phase)
            0: write_reg(REG_NUM_STAGES, 4);
            1: write_reg(REG_NUM_STAGES, 7);
            2: write_reg(REG_NUM_STAGES, 0);
            default: write_reg(REG_NUM_STAGES, CFG_DATA_W'($urandom_range(1, 7)));
        endcase
        case (phase)
            0: g = 16'h7FFF;
            1: g = 16'h8000;
            3: g = '0;
            default: g = CFG_DATA_W'($urandom);
        endcase
        write_reg(REG_GAIN, g);
        for (s = 0; s < MAX_STAGES; s++) begin
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0: write_reg(REG_DELAY0 + s, 0);
                    1: write_reg(REG_DELAY0 + s, CFG_DATA_W'(MAX_DELAY));
                    2: write_reg(REG_DELAY0 + s,
                                 CFG_DATA_W'($urandom_range(MAX_DELAY + 1, 2047)));
                    default: write_reg(REG_DELAY0 + s,
                                       CFG_DATA_W'($urandom_range(1, 37)));
                endcase
            end
        end
    endtask

    task automatic test_random_phases();
        int phase, k;
        for (phase = 0; phase < 8; phase++) begin
            pick_setting(phase);
            for (k = 0; k < 70; k++) push_sample(rand_sample());
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        src_idle_on      = 1'b0;
        sink_hold_cycles = 400;
        for (k = 0; k < 30; k++) push_sample(rand_sample());
        drain();
        src_idle_on = 1'b1;
    endtask

    task automatic test_full_rate();
        int k;
        write_reg(REG_NUM_STAGES, 4);
        write_reg(REG_GAIN, CFG_DATA_W'($urandom));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (k = 0; k < 60; k++) push_sample(rand_sample());
        drain();
    endtask

    // Output side: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            if (sink_hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        logic signed [SAMPLE_WIDTH-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (chain_out_q.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, got %0d",
                         $time, o_sample_out);
                err_cnt++;
            end else begin
                want = chain_out_q.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want, o_sample_out);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int k;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;
        err_cnt          = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = 0;
        for (k = 0; k < MAX_STAGES * MAX_DELAY; k++) dline_mem[k] = 0;
        for (k = 0; k < MAX_STAGES; k++) begin
            tap_ptr[k]   = 0;
            cfg_delay[k] = 1;
        end
        cfg_stages = '0;
        cfg_gain   = 16'sd16384;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_saturation_and_limits();
        test_delay_rewrite();
        test_random_phases();
        test_output_backpressure();
        test_full_rate();

        if (err_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
